[rtl/core/assert_macros.svh]
// Assertion helper macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled during reset
`define HSE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define HSE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/hse_pkg.sv]
`timescale 1ns / 1ps
package hse_pkg;

    localparam int FIT_W = 33;
    localparam logic [FIT_W-1:0] FIT_MAX = {FIT_W{1'b1}};

    // Configuration register indexes
    localparam logic [2:0] REG_LOWER   = 3'd0;
    localparam logic [2:0] REG_UPPER   = 3'd1;
    localparam logic [2:0] REG_CONSIDER = 3'd2;
    localparam logic [2:0] REG_ADJUST  = 3'd3;
    localparam logic [2:0] REG_RANGE   = 3'd4;

    // Item as queued between front and back
    typedef struct packed {
        logic        kind;
        logic [15:0] consider_draw;
        logic [15:0] pick_draw;
        logic [15:0] adjust_draw;
        logic [15:0] uniform_draw;
    } item_t;

    // Configuration bundle
    typedef struct packed {
        logic signed [15:0] lower_bound;
        logic signed [15:0] upper_bound;
        logic [15:0]        consider_rate;
        logic [15:0]        pitch_rate;
        logic [14:0]        adjust_range;
    } cfg_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_VALUE,
        ST_CLAMP,
        ST_SQUARE,
        ST_ACCUM,
        ST_SCAN,
        ST_COMPARE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_OUT
    } state_t;

endpackage

[rtl/core/harmony_search_engine_core.sv]
// Each item passes the back-end states READ, VALUE, CLAMP, SQUARE and ACCUM,
// then OUT; the last component of a candidate adds the sorted insertion (SCAN
// and COMPARE per entry scanned, SHIFT_RD and SHIFT_WR per component shifted,
// PLACE per component). A new item is taken only in IDLE; a finished result
// waits in OUT while the output register is full and m_ready is low.
// Reset: synchronous, active low; clears counts, accumulator, queue, registers.
`timescale 1ns / 1ps
module harmony_search_engine_core #(
    parameter int POOL_SIZE = 20,
    parameter int DIMS      = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_consider_draw,
    input  logic [15:0] s_pick_draw,
    input  logic [15:0] s_adjust_draw,
    input  logic [15:0] s_uniform_draw,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_component_value,
    output logic        m_candidate_done,
    output logic [32:0] m_candidate_fitness,
    output logic        m_kept,
    output logic [32:0] m_best_fitness
);
    hse_pkg::cfg_t  cfg_reg;
    hse_pkg::item_t in_item, q_item;
    logic           q_valid, q_ready;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lower_bound   <= -16'sd1280;
            cfg_reg.upper_bound   <= 16'sd1280;
            cfg_reg.consider_rate <= 16'd62259;
            cfg_reg.pitch_rate    <= 16'd45875;
            cfg_reg.adjust_range  <= 15'd13;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                hse_pkg::REG_LOWER:    cfg_reg.lower_bound   <= pwdata[15:0];
                hse_pkg::REG_UPPER:    cfg_reg.upper_bound   <= pwdata[15:0];
                hse_pkg::REG_CONSIDER: cfg_reg.consider_rate <= pwdata[15:0];
                hse_pkg::REG_ADJUST:   cfg_reg.pitch_rate    <= pwdata[15:0];
                hse_pkg::REG_RANGE:    cfg_reg.adjust_range  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            hse_pkg::REG_LOWER:    prdata = 32'($signed(cfg_reg.lower_bound));
            hse_pkg::REG_UPPER:    prdata = 32'($signed(cfg_reg.upper_bound));
            hse_pkg::REG_CONSIDER: prdata = 32'(cfg_reg.consider_rate);
            hse_pkg::REG_ADJUST:   prdata = 32'(cfg_reg.pitch_rate);
            hse_pkg::REG_RANGE:    prdata = 32'(cfg_reg.adjust_range);
            default:               prdata = 32'd0;
        endcase
    end

    assign in_item = '{kind: s_kind, consider_draw: s_consider_draw,
                       pick_draw: s_pick_draw, adjust_draw: s_adjust_draw,
                       uniform_draw: s_uniform_draw};

    hse_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    hse_back #(.POOL_SIZE(POOL_SIZE), .DIMS(DIMS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_component_value(m_component_value),
        .m_candidate_done(m_candidate_done),
        .m_candidate_fitness(m_candidate_fitness),
        .m_kept(m_kept), .m_best_fitness(m_best_fitness)
    );
endmodule

[rtl/core/hse_ram.sv]
`timescale 1ns / 1ps
module hse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/hse_front.sv]
`timescale 1ns / 1ps
module hse_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  hse_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_ready,
    output hse_pkg::item_t q_item
);
    // Two-entry queue
    hse_pkg::item_t buf_reg [2];
    logic [1:0] count_reg, count_next;
    logic       rd_ptr_reg, wr_ptr_reg;
    logic       push, pop;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = buf_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_item;
        end
    end
endmodule

[rtl/core/hse_back.sv]
`timescale 1ns / 1ps
module hse_back #(
    parameter int POOL_SIZE = 20,
    parameter int DIMS      = 3
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  hse_pkg::cfg_t            cfg,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  hse_pkg::item_t           q_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [15:0]       m_component_value,
    output logic                     m_candidate_done,
    output logic [hse_pkg::FIT_W-1:0] m_candidate_fitness,
    output logic                     m_kept,
    output logic [hse_pkg::FIT_W-1:0] m_best_fitness
);
    localparam int PW  = $clog2(POOL_SIZE + 1);
    localparam int IW  = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int DW  = (DIMS > 1) ? $clog2(DIMS) : 1;
    localparam int VD  = POOL_SIZE * DIMS;
    localparam int VAW = $clog2(VD);
    localparam int FW  = hse_pkg::FIT_W;

    hse_pkg::state_t state_reg, state_next;
    hse_pkg::item_t  item_reg;
    logic [PW-1:0]   pool_count_reg;
    logic [DW-1:0]   ci_reg;
    logic [FW-1:0]   acc_reg;
    logic [FW-1:0]   best_reg;
    logic signed [15:0] build_reg [DIMS];
    logic signed [15:0] value_reg;
    logic signed [17:0] wide_reg;
    logic [31:0]     sq_reg;
    logic            use_mem_reg;
    logic [PW-1:0]   pos_reg;
    logic [PW-1:0]   shift_reg;
    logic [DW-1:0]   dim_reg;
    logic            done_reg, kept_reg;
    logic [FW-1:0]   cand_reg;
    logic            out_valid_reg;
    logic            out_load;

    // Pool memories
    logic            v_we, f_we;
    logic [VAW-1:0]  v_waddr, v_raddr;
    logic [15:0]     v_wdata, v_rdata;
    logic [IW-1:0]   f_waddr, f_raddr;
    logic [FW-1:0]   f_wdata, f_rdata;

    hse_ram #(.WIDTH(16), .DEPTH(VD)) u_values (
        .aclk(aclk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );
    hse_ram #(.WIDTH(FW), .DEPTH(POOL_SIZE)) u_fitness (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    // Arithmetic helpers
    logic signed [16:0] span;
    logic signed [33:0] fresh_prod;
    logic signed [16:0] off_draw;
    logic signed [32:0] off_prod;
    logic [PW+15:0]     pick_prod;
    logic [FW:0]        acc_sum;
    logic [FW-1:0]      acc_sat;
    logic               last_comp;
    logic [PW-1:0]      last_idx;
    logic signed [17:0] clamp_v;

    assign span       = 17'(cfg.upper_bound) - 17'(cfg.lower_bound);
    assign fresh_prod = 34'(span) * $signed({1'b0, item_reg.uniform_draw});
    assign off_draw   = $signed({item_reg.uniform_draw, 1'b0}) - 17'sd32768 - 17'sd32768;
    assign off_prod   = $signed({1'b0, cfg.adjust_range}) * 33'(off_draw);
    assign pick_prod  = item_reg.pick_draw * (pool_count_reg - PW'(1));
    assign acc_sum    = {1'b0, acc_reg} + (FW+1)'(sq_reg);
    assign acc_sat    = (acc_sum > (FW+1)'(hse_pkg::FIT_MAX)) ? hse_pkg::FIT_MAX
                                                              : acc_sum[FW-1:0];
    assign last_comp  = (ci_reg == DW'(DIMS - 1));
    assign last_idx   = (pool_count_reg < PW'(POOL_SIZE)) ? pool_count_reg
                                                          : PW'(POOL_SIZE - 1);

    // Clamp: lower bound first, so the upper bound wins when reversed
    always_comb begin
        clamp_v = wide_reg;
        if (clamp_v < 18'(cfg.lower_bound)) begin
            clamp_v = 18'(cfg.lower_bound);
        end
        if (clamp_v > 18'(cfg.upper_bound)) begin
            clamp_v = 18'(cfg.upper_bound);
        end
    end

    // Output register takes a new item when empty or being drained
    assign out_load = (state_reg == hse_pkg::ST_OUT) && (!out_valid_reg || m_ready);
    assign q_ready  = (state_reg == hse_pkg::ST_IDLE);
    assign m_valid  = out_valid_reg;

    // Next state and memory control
    always_comb begin
        state_next = state_reg;
        v_we = 1'b0; f_we = 1'b0;
        v_waddr = '0; v_wdata = '0; f_waddr = '0; f_wdata = '0;
        // picked entry, valid from READ on; fitness at the scan position
        v_raddr = VAW'(32'(pick_prod >> 16) * DIMS + 32'(ci_reg));
        f_raddr = IW'(pos_reg);
        case (state_reg)
            hse_pkg::ST_IDLE: begin
                if (q_valid) begin
                    state_next = hse_pkg::ST_READ;
                end
            end
            hse_pkg::ST_READ:   state_next = hse_pkg::ST_VALUE;
            hse_pkg::ST_VALUE:  state_next = hse_pkg::ST_CLAMP;
            hse_pkg::ST_CLAMP:  state_next = hse_pkg::ST_SQUARE;
            hse_pkg::ST_SQUARE: state_next = hse_pkg::ST_ACCUM;
            hse_pkg::ST_ACCUM: begin
                state_next = last_comp ? hse_pkg::ST_SCAN : hse_pkg::ST_OUT;
            end
            hse_pkg::ST_SCAN: begin
                // address of entry pos goes out; compare next cycle
                if (pos_reg < pool_count_reg) begin
                    state_next = hse_pkg::ST_COMPARE;
                end else if (pool_count_reg >= PW'(POOL_SIZE)) begin
                    state_next = hse_pkg::ST_OUT;
                end else begin
                    state_next = (last_idx > pos_reg) ? hse_pkg::ST_SHIFT_RD
                                                      : hse_pkg::ST_PLACE;
                end
            end
            hse_pkg::ST_COMPARE: begin
                // ties move past the older entry
                if (f_rdata <= cand_reg) begin
                    state_next = hse_pkg::ST_SCAN;
                end else begin
                    state_next = (last_idx > pos_reg) ? hse_pkg::ST_SHIFT_RD
                                                      : hse_pkg::ST_PLACE;
                end
            end
            hse_pkg::ST_SHIFT_RD: begin
                f_raddr = IW'(shift_reg - PW'(1));
                v_raddr = VAW'(32'(shift_reg - PW'(1)) * DIMS + 32'(dim_reg));
                state_next = hse_pkg::ST_SHIFT_WR;
            end
            hse_pkg::ST_SHIFT_WR: begin
                v_we = 1'b1;
                v_waddr = VAW'(32'(shift_reg) * DIMS + 32'(dim_reg));
                v_wdata = v_rdata;
                f_we = (dim_reg == '0);
                f_waddr = IW'(shift_reg);
                f_wdata = f_rdata;
                if (dim_reg == DW'(DIMS - 1)) begin
                    state_next = ((shift_reg - PW'(1)) > pos_reg) ? hse_pkg::ST_SHIFT_RD
                                                                  : hse_pkg::ST_PLACE;
                end else begin
                    state_next = hse_pkg::ST_SHIFT_RD;
                end
            end
            hse_pkg::ST_PLACE: begin
                v_we = 1'b1;
                v_waddr = VAW'(32'(pos_reg) * DIMS + 32'(dim_reg));
                v_wdata = build_reg[dim_reg];
                f_we = (dim_reg == '0);
                f_waddr = IW'(pos_reg);
                f_wdata = cand_reg;
                state_next = (dim_reg == DW'(DIMS - 1)) ? hse_pkg::ST_OUT
                                                        : hse_pkg::ST_PLACE;
            end
            hse_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = hse_pkg::ST_IDLE;
                end
            end
            default:            state_next = hse_pkg::ST_IDLE;
        endcase
    end

    // State, counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= hse_pkg::ST_IDLE;
            pool_count_reg <= '0;
            ci_reg         <= '0;
            acc_reg        <= '0;
            best_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                hse_pkg::ST_ACCUM: begin
                    acc_reg <= last_comp ? '0 : acc_sat;
                    ci_reg  <= last_comp ? '0 : ci_reg + DW'(1);
                end
                hse_pkg::ST_PLACE: begin
                    if (dim_reg == DW'(DIMS - 1)) begin
                        if (pool_count_reg < PW'(POOL_SIZE)) begin
                            pool_count_reg <= pool_count_reg + PW'(1);
                        end
                        if (pos_reg == '0) begin
                            best_reg <= cand_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            hse_pkg::ST_IDLE: begin
                if (q_valid) begin
                    item_reg <= q_item;
                end
            end
            hse_pkg::ST_READ: begin
                use_mem_reg <= item_reg.kind && (pool_count_reg != '0)
                               && (item_reg.consider_draw < cfg.consider_rate);
            end
            hse_pkg::ST_VALUE: begin
                // v_rdata holds the picked entry now
                if (use_mem_reg) begin
                    if (item_reg.adjust_draw < cfg.pitch_rate) begin
                        wide_reg <= 18'($signed(v_rdata)) + 18'(off_prod >>> 16);
                    end else begin
                        wide_reg <= 18'($signed(v_rdata));
                    end
                end else begin
                    wide_reg <= 18'(cfg.lower_bound) + 18'(fresh_prod >>> 16);
                end
            end
            hse_pkg::ST_CLAMP: begin
                value_reg <= use_mem_reg ? clamp_v[15:0] : wide_reg[15:0];
            end
            hse_pkg::ST_SQUARE: begin
                sq_reg <= 32'(value_reg) * 32'(value_reg);
                build_reg[ci_reg] <= value_reg;
            end
            hse_pkg::ST_ACCUM: begin
                pos_reg  <= '0;
                dim_reg  <= '0;
                done_reg <= last_comp;
                kept_reg <= 1'b0;
                cand_reg <= acc_sat;
            end
            hse_pkg::ST_SCAN: begin
                shift_reg <= last_idx;
                dim_reg   <= '0;
            end
            hse_pkg::ST_COMPARE: begin
                if (f_rdata <= cand_reg) begin
                    pos_reg <= pos_reg + PW'(1);
                end
                shift_reg <= last_idx;
                dim_reg   <= '0;
            end
            hse_pkg::ST_SHIFT_WR: begin
                if (dim_reg == DW'(DIMS - 1)) begin
                    dim_reg   <= '0;
                    shift_reg <= shift_reg - PW'(1);
                end else begin
                    dim_reg <= dim_reg + DW'(1);
                end
            end
            hse_pkg::ST_PLACE: begin
                kept_reg <= 1'b1;
                dim_reg  <= dim_reg + DW'(1);
            end
            hse_pkg::ST_OUT: begin
                if (out_load) begin
                    m_component_value   <= value_reg;
                    m_candidate_done    <= done_reg;
                    m_candidate_fitness <= done_reg ? cand_reg : '0;
                    m_kept              <= kept_reg;
                    m_best_fitness      <= best_reg;
                end
            end
            default: ;
        endcase
    end
endmodule

[rtl/core/hse_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_candidate_done,
    input logic [32:0] m_candidate_fitness,
    input logic        m_kept,
    input logic [32:0] m_best_fitness
);
    `HSE_ASSERT_IMP(a_fit_zero, aclk, aresetn, m_valid && !m_candidate_done, m_candidate_fitness == 33'd0)
    `HSE_ASSERT_IMP(a_kept_done, aclk, aresetn, m_valid && m_kept, m_candidate_done)
    `HSE_ASSERT_IMP(a_best_le, aclk, aresetn, m_valid && m_kept, m_best_fitness <= m_candidate_fitness)
    `HSE_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule

bind harmony_search_engine_core hse_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_candidate_done(m_candidate_done), .m_candidate_fitness(m_candidate_fitness),
    .m_kept(m_kept), .m_best_fitness(m_best_fitness)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

    localparam int POOL = 20;
    localparam int NDIM = 3;
    localparam longint FIT_SAT = 64'h1_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 3_000_000;

    // Component result as predicted and as observed
    typedef struct {
        logic signed [15:0] value;
        logic               done;
        logic [32:0]        cand_fit;
        logic               kept;
        logic [32:0]        best_fit;
    } component_t;

    // Harmony memory predictor plus queue of pending component results
    class harmony_board;
        int lower, upper;
        int unsigned consider, adjust, range;
        int mem_value [POOL*NDIM];
        longint mem_fit [POOL];
        int unsigned count;
        int partial [NDIM];
        int unsigned slot;
        longint accum;
        component_t pending [$];
        int errors;

        function new();
            lower = -1280; upper = 1280; consider = 62259; adjust = 45875; range = 13;
            count = 0; slot = 0; accum = 0; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                hse_pkg::REG_LOWER:    lower = $signed(val[15:0]);
                hse_pkg::REG_UPPER:    upper = $signed(val[15:0]);
                hse_pkg::REG_CONSIDER: consider = val[15:0];
                hse_pkg::REG_ADJUST:   adjust = val[15:0];
                hse_pkg::REG_RANGE:    range = val[14:0];
                default: ;
            endcase
        endfunction

        // floor division by 65536
        function longint floor16(longint v);
            return v >>> 16;
        endfunction

        function void note_item(logic kind, logic [15:0] cd, logic [15:0] pd,
                                logic [15:0] ad, logic [15:0] ud);
            component_t r;
            longint v, sq;
            int unsigned idx, pos, last;
            r.done = 0; r.cand_fit = 0; r.kept = 0;
            if (kind && count > 0 && cd < consider) begin
                idx = (longint'(pd) * (count - 1)) >> 16;
                v = mem_value[idx*NDIM + slot];
                if (ad < adjust)
                    v += floor16(longint'(range) * (longint'(ud) * 2 - 65536));
                if (v < lower) v = lower;
                if (v > upper) v = upper;
            end else begin
                v = lower + floor16((longint'(upper) - lower) * longint'(ud));
            end
            r.value = v[15:0];
            partial[slot] = v;
            sq = v * v;
            accum += sq;
            if (accum > FIT_SAT) accum = FIT_SAT;
            if (slot + 1 >= NDIM) begin
                r.done = 1;
                r.cand_fit = accum[32:0];
                // sorted insertion, ties keep older entry first
                pos = 0;
                while (pos < count && mem_fit[pos] <= accum) pos++;
                if (!(count >= POOL && pos >= POOL)) begin
                    last = (count < POOL) ? count : POOL - 1;
                    for (int i = last; i > pos; i--) begin
                        mem_fit[i] = mem_fit[i-1];
                        for (int d = 0; d < NDIM; d++)
                            mem_value[i*NDIM+d] = mem_value[(i-1)*NDIM+d];
                    end
                    mem_fit[pos] = accum;
                    for (int d = 0; d < NDIM; d++) mem_value[pos*NDIM+d] = partial[d];
                    if (count < POOL) count++;
                    r.kept = 1;
                end
                accum = 0;
                slot = 0;
            end else begin
                slot++;
            end
            r.best_fit = (count > 0) ? mem_fit[0][32:0] : '0;
            pending = {pending, r};
        endfunction

        function void check_result(component_t got);
            component_t e;
            if (pending.size() == 0) begin
                $error("unexpected item: value %0d", got.value);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.value !== e.value) begin
                $error("component_value exp %0d got %0d", e.value, got.value); errors++;
            end
            if (got.done !== e.done) begin
                $error("candidate_done exp %0d got %0d", e.done, got.done); errors++;
            end
            if (got.cand_fit !== e.cand_fit) begin
                $error("candidate_fitness exp %0d got %0d", e.cand_fit, got.cand_fit);
                errors++;
            end
            if (got.kept !== e.kept) begin
                $error("kept exp %0d got %0d", e.kept, got.kept); errors++;
            end
            if (got.best_fit !== e.best_fit) begin
                $error("best_fitness exp %0d got %0d", e.best_fit, got.best_fit);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_kind = 0;
    logic [15:0] s_consider_draw = '0, s_pick_draw = '0, s_adjust_draw = '0;
    logic [15:0] s_uniform_draw = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic signed [15:0] m_component_value;
    logic        m_candidate_done;
    logic [32:0] m_candidate_fitness;
    logic        m_kept;
    logic [32:0] m_best_fitness;

    harmony_search_engine_core dut (.*);

    harmony_board board = new();
    int  hold_off = 0;
    bit  long_hold_req = 0;
    longint cycles = 0;

    initial forever #1 aclk = ~aclk;

    // Cycle limit watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: own stall pattern, plus one long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            component_t got;
            got.value = m_component_value;
            got.done = m_candidate_done;
            got.cand_fit = m_candidate_fitness;
            got.kept = m_kept;
            got.best_fit = m_best_fitness;
            board.check_result(got);
        end
        if (long_hold_req) begin
            long_hold_req <= 0;
            hold_off <= 400;
            m_ready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else if (cycles[10]) begin
            m_ready <= 1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        board.set_reg(idx, val);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
    endtask

    // Offer one item; returns after acceptance
    task automatic send_item(logic kind, logic [15:0] cd, logic [15:0] pd,
                             logic [15:0] ad, logic [15:0] ud);
        s_valid <= 1; s_kind <= kind; s_consider_draw <= cd; s_pick_draw <= pd;
        s_adjust_draw <= ad; s_uniform_draw <= ud;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_item(kind, cd, pd, ad, ud);
    endtask

    task automatic pause_sender();
        s_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (8 * POOL * NDIM + 50) @(posedge aclk);
    endtask

    // Random phase: bursts of random length, mostly improvisation
    task automatic random_items(int n, bit extreme_draws);
        int burst;
        logic [15:0] d [4];
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) begin
                if (!cycles[9]) pause_sender();
                burst = $urandom_range(1, 20);
            end
            burst--;
            for (int j = 0; j < 4; j++)
                d[j] = (extreme_draws && $urandom_range(0, 3) == 0) ?
                       ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
            send_item($urandom_range(0, 9) != 0, d[0], d[1], d[2], d[3]);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty memory improvise, extremes of draws, then fill
        send_item(1, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_item(0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_item(1, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
        for (int k = 0; k < 9; k++)
            send_item(k[0], 16'h0000, 16'($urandom), 16'h0000, 16'($urandom));
        send_item(1, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_item(1, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_item(1, 16'hFFFF, 16'h8000, 16'h0000, 16'h0001);
        // identical candidate for tie ordering
        repeat (2) begin
            send_item(0, 16'h0, 16'h0, 16'h0, 16'h4000);
            send_item(0, 16'h0, 16'h0, 16'h0, 16'h4000);
            send_item(0, 16'h0, 16'h0, 16'h0, 16'h4000);
        end
        drain();

        // Default setting, with the long receiver hold-off
        long_hold_req <= 1;
        random_items(400, 0);
        drain();

        // Reversed bounds, wide perturbation, maximum consider and adjust rates
        write_reg(hse_pkg::REG_LOWER, 32'h0000_0200);
        write_reg(hse_pkg::REG_UPPER, 32'h0000_FE00);
        write_reg(hse_pkg::REG_CONSIDER, 32'h0000_FFFF);
        write_reg(hse_pkg::REG_ADJUST, 32'h0000_FFFF);
        write_reg(hse_pkg::REG_RANGE, 32'h0000_7FFF);
        random_items(300, 1);
        drain();

        // Full range bounds, never consider
        write_reg(hse_pkg::REG_LOWER, 32'h0000_8000);
        write_reg(hse_pkg::REG_UPPER, 32'h0000_7FFF);
        write_reg(hse_pkg::REG_CONSIDER, 32'h0);
        write_reg(hse_pkg::REG_ADJUST, 32'h0);
        write_reg(hse_pkg::REG_RANGE, 32'h0);
        random_items(300, 1);
        drain();

        // Narrow bounds, mid rates, random range
        write_reg(hse_pkg::REG_LOWER, 32'h0000_FF00);
        write_reg(hse_pkg::REG_UPPER, 32'h0000_0100);
        write_reg(hse_pkg::REG_CONSIDER, 32'h0000_C000);
        write_reg(hse_pkg::REG_ADJUST, 32'h0000_8000);
        write_reg(hse_pkg::REG_RANGE, 32'($urandom_range(1, 600)));
        random_items(630, 0);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

[harmony_search_engine_core.f]
+incdir+rtl/core
rtl/core/hse_pkg.sv
rtl/core/hse_ram.sv
rtl/core/hse_front.sv
rtl/core/hse_back.sv
rtl/core/harmony_search_engine_core.sv
rtl/core/hse_checker.sv
tb/sv/tb_top.sv
